>>> rtl/core/itp_pkg.sv
// Shared constants, widths and character helpers for the infix to prefix converter.
package itp_pkg;

  // Operator stack geometry.
  localparam int STACK_DEPTH = 32;
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  // Character codes the converter recognizes.
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;

  // Precedence shifted up by one so that it fits an unsigned field:
  // caret 4, multiply and divide 3, add and subtract 2, anything else 0.
  function automatic logic [2:0] prec_rank(input logic [7:0] c);
    logic [2:0] r;
    begin
      r = 3'd0;
      if (c == CH_CARET) begin
        r = 3'd4;
      end else if (c == CH_STAR || c == CH_SLASH) begin
        r = 3'd3;
      end else if (c == CH_PLUS || c == CH_MINUS) begin
        r = 3'd2;
      end
      return r;
    end
  endfunction

  // True for an ASCII letter, upper or lower case.
  function automatic logic is_letter(input logic [7:0] c);
    begin
      return ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
    end
  endfunction

endpackage

>>> rtl/core/infix_to_prefix_converter_top.sv
// Infix to prefix converter: operator stack, stack sequencer and output register.
//
// The block reads an infix expression one byte per input transaction, from the
// last character to the first, with tlast marking the first infix character.
// Letters come out at once, operators go through a 32-entry operator stack, and
// the bytes emitted, read in reverse, form the prefix string. An input
// transaction is taken only while the block is idle. It first pops the
// entries that must go before its own step (its push, its letter, or the drop
// of a matching closing parenthesis). The first infix character then flushes
// the entries left on the stack. The sequencer does one stack step per cycle
// through the single stack port, unless a stalled output holds it. Every
// emitted byte is held one step in a pending register so its run_last flag is
// known when it is sent; a stalled output stalls the sequencer. A final
// character that emits nothing yields one bare end marker with char_valid low.
// A push onto a full stack is dropped and sets overflow_seen, which stays set
// on every output until the expression ends.
module infix_to_prefix_converter_top
  import itp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // Input stream.
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_char
  input  logic       s_tlast,   // final_char
  // Output stream.
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_char
  output logic       m_tlast,   // run_last
  output logic [2:0] m_tuser    // [0] char_valid, [1] expression_end, [2] overflow_seen
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_FLUSH  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [7:0]       cur_char;
  logic             cur_fin;
  logic [7:0]       op_stack [STACK_DEPTH];
  logic [CNT_W-1:0] stack_count;
  logic             overflow_flag;
  logic             pend_valid;
  logic [7:0]       pend_char;
  logic [7:0]       out_char;
  logic             out_char_valid;
  logic             out_run_last;
  logic             out_expr_end;
  logic             out_overflow;

  logic [CNT_W-1:0] top_sum;
  logic [IDX_W-1:0] top_idx;
  logic [7:0]       top_char;
  logic             stack_empty;
  logic             stack_full;
  logic             out_free;
  logic             step_en;
  logic             do_pop;
  logic             do_push;
  logic             do_emit;
  logic [7:0]       emit_char;
  logic             push_ok;
  logic             out_load;
  state_t           after_scan;

  // Stack top and handshake status.
  assign top_sum     = stack_count - CNT_W'(1);
  assign top_idx     = top_sum[IDX_W-1:0];
  assign top_char    = op_stack[top_idx];
  assign stack_empty = (stack_count == '0);
  assign stack_full  = (stack_count == CNT_W'(STACK_DEPTH));
  assign out_free    = !m_tvalid || m_tready;
  assign step_en     = !pend_valid || out_free;
  assign s_tready    = (state == ST_IDLE);
  assign after_scan  = cur_fin ? ST_FLUSH : ST_FINISH;

  // One stack step per cycle unless the output stalls: decide pop, push and emit.
  always_comb begin
    do_pop     = 1'b0;
    do_push    = 1'b0;
    do_emit    = 1'b0;
    emit_char  = top_char;
    state_next = state;
    case (state)
      ST_SCAN: begin
        if (is_letter(cur_char)) begin
          do_emit    = 1'b1;
          emit_char  = cur_char;
          state_next = after_scan;
        end else if (cur_char == CH_RPAREN) begin
          do_push    = 1'b1;
          state_next = after_scan;
        end else if (cur_char == CH_LPAREN) begin
          if (!stack_empty && (top_char != CH_RPAREN)) begin
            do_pop  = 1'b1;
            do_emit = 1'b1;
          end else begin
            // Drop the matching closing parenthesis, if there is one.
            do_pop     = !stack_empty;
            state_next = after_scan;
          end
        end else begin
          if (!stack_empty && (prec_rank(top_char) > prec_rank(cur_char))) begin
            do_pop  = 1'b1;
            do_emit = 1'b1;
          end else begin
            do_push    = 1'b1;
            state_next = after_scan;
          end
        end
      end
      ST_FLUSH: begin
        if (!stack_empty) begin
          do_pop  = 1'b1;
          do_emit = 1'b1;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_next = ST_IDLE;
      end
      ST_IDLE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign push_ok = (state == ST_SCAN) && step_en && do_push && !stack_full;

  // Output register loads when a pending byte is displaced or finish has one to send.
  assign out_load = (((state == ST_SCAN) || (state == ST_FLUSH)) && step_en && do_emit &&
                     pend_valid) ||
                    ((state == ST_FINISH) && (pend_valid || cur_fin) && out_free);

  // Operator stack storage.
  always_ff @(posedge clk) begin
    if (push_ok) begin
      op_stack[stack_count[IDX_W-1:0]] <= cur_char;
    end
  end

  // Sequencer, stack pointer, pending byte and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      stack_count   <= '0;
      overflow_flag <= 1'b0;
      pend_valid    <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cur_char   <= s_tdata;
            cur_fin    <= s_tlast;
            pend_valid <= 1'b0;
            state      <= ST_SCAN;
          end
        end
        ST_SCAN, ST_FLUSH: begin
          if (step_en) begin
            state <= state_next;
            if (do_pop) begin
              stack_count <= top_sum;
            end
            if (do_push) begin
              if (stack_full) begin
                overflow_flag <= 1'b1;
              end else begin
                stack_count <= stack_count + CNT_W'(1);
              end
            end
            if (do_emit) begin
              // A newer byte exists, so the pending one is not the last.
              if (pend_valid) begin
                out_char       <= pend_char;
                out_char_valid <= 1'b1;
                out_run_last   <= 1'b0;
                out_expr_end   <= 1'b0;
                out_overflow   <= overflow_flag;
              end
              pend_valid <= 1'b1;
              pend_char  <= emit_char;
            end
          end
        end
        ST_FINISH: begin
          if (pend_valid || cur_fin) begin
            if (out_free) begin
              out_char       <= pend_valid ? pend_char : 8'h00;
              out_char_valid <= pend_valid;
              out_run_last   <= 1'b1;
              out_expr_end   <= cur_fin;
              out_overflow   <= overflow_flag;
              pend_valid     <= 1'b0;
              if (cur_fin) begin
                overflow_flag <= 1'b0;
              end
              state <= ST_IDLE;
            end
          end else begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output stream packing.
  assign m_tdata = out_char;
  assign m_tlast = out_run_last;
  assign m_tuser = {out_overflow, out_expr_end, out_char_valid};

endmodule

>>> tb/infix_to_prefix_converter_top_tb.sv
// Self-checking testbench for the infix to prefix converter: directed table, then random expressions.
`timescale 1ns / 1ps

module infix_to_prefix_converter_top_tb
  import itp_pkg::*;
();

  // One output transaction as seen on the master side.
  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       run_last;
    logic       expr_end;
    logic       ovf;
  } prefix_byte_t;

  // An entry that may pin the outcome of one input transaction to a typed-in value.
  typedef struct packed {
    logic         pinned;
    prefix_byte_t want;
  } pin_t;

  // One row of the directed table.
  typedef struct packed {
    logic [7:0]   ch;
    logic         is_first;
    logic         pinned;
    prefix_byte_t want;
  } row_t;

  localparam int NUM_ROWS = 26;

  logic       clk = 1'b0;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       s_tlast;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic [2:0] m_tuser;

  // Local copy of the converter state.
  logic [7:0] op_mem [STACK_DEPTH];
  int         op_cnt;
  logic       ovf_flag;

  prefix_byte_t prefix_bytes_q [$];
  prefix_byte_t step_bytes [$];
  pin_t         pinned_q [$];
  logic [7:0]   infix_q [$];
  row_t         directed_rows [NUM_ROWS];

  int  errors;
  int  items_sent;
  int  bytes_checked;
  int  exprs_closed;
  int  ovf_results;
  int  stall_left;
  bit  steady;

  infix_to_prefix_converter_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // Clock generation.
  always #4 clk = ~clk;

  // Operator precedence, with -1 for anything that is not an arithmetic operator.
  function automatic int rank_of(input logic [7:0] c);
    if (c == CH_CARET) return 3;
    if (c == CH_STAR || c == CH_SLASH) return 2;
    if (c == CH_PLUS || c == CH_MINUS) return 1;
    return -1;
  endfunction

  function automatic bit letter(input logic [7:0] c);
    return (c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
  endfunction

  function automatic void stack_push(input logic [7:0] c);
    if (op_cnt >= STACK_DEPTH) begin
      ovf_flag = 1'b1;
    end else begin
      op_mem[op_cnt] = c;
      op_cnt++;
    end
  endfunction

  // Works out the prefix bytes one input character produces, into step_bytes.
  function automatic void convert_char(input logic [7:0] c, input bit is_first);
    logic [7:0] popped [$];
    int         p;
    step_bytes.delete();
    if (letter(c)) begin
      popped.push_back(c);
    end else if (c == CH_RPAREN) begin
      stack_push(c);
    end else if (c == CH_LPAREN) begin
      while (op_cnt > 0 && op_mem[op_cnt-1] != CH_RPAREN) begin
        op_cnt--;
        popped.push_back(op_mem[op_cnt]);
      end
      if (op_cnt > 0) op_cnt--;
    end else begin
      p = rank_of(c);
      while (op_cnt > 0 && rank_of(op_mem[op_cnt-1]) > p) begin
        op_cnt--;
        popped.push_back(op_mem[op_cnt]);
      end
      stack_push(c);
    end
    // The first infix character drains the stack, top first.
    if (is_first) begin
      while (op_cnt > 0) begin
        op_cnt--;
        popped.push_back(op_mem[op_cnt]);
      end
    end
    if (popped.size() == 0) begin
      if (is_first) begin
        step_bytes.push_back('{8'h00, 1'b0, 1'b1, 1'b1, ovf_flag});
        ovf_flag = 1'b0;
      end
      return;
    end
    foreach (popped[k]) begin
      step_bytes.push_back('{popped[k], 1'b1, k == popped.size() - 1,
                             (k == popped.size() - 1) && is_first, ovf_flag});
    end
    if (is_first) ovf_flag = 1'b0;
  endfunction

  // Builds a well-formed random infix expression into infix_q.
  function automatic void build_expr(input int depth);
    logic [7:0] ops [5];
    int         pick;
    ops = '{CH_CARET, CH_STAR, CH_SLASH, CH_PLUS, CH_MINUS};
    pick = $urandom_range(0, 99);
    if (depth == 0 || pick < 25) begin
      if ($urandom_range(0, 1) == 1)
        infix_q.push_back(8'($urandom_range(CH_LOW_A, CH_LOW_Z)));
      else
        infix_q.push_back(8'($urandom_range(CH_UP_A, CH_UP_Z)));
    end else if (pick < 45) begin
      infix_q.push_back(CH_LPAREN);
      build_expr(depth - 1);
      infix_q.push_back(CH_RPAREN);
    end else begin
      build_expr(depth - 1);
      infix_q.push_back(ops[$urandom_range(0, 4)]);
      build_expr(depth - 1);
    end
  endfunction

  // Idle length: mostly short, now and then long.
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drives one input transaction and waits until the block takes it.
  task automatic feed_char(input logic [7:0] c, input bit is_first, input bit pinned,
                           input prefix_byte_t want);
    int idle;
    idle = (steady || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
    pinned_q.push_back('{pinned, want});
    if (idle > 0) begin
      s_tvalid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= is_first;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // Output backpressure with random stalls.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (!steady && $urandom_range(0, 99) < 30) begin
      stall_left = pick_gap() - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Input side prediction, then output side comparison, at each edge.
  always @(posedge clk) begin
    pin_t         pin;
    prefix_byte_t want;
    prefix_byte_t got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        pin = pinned_q.pop_front();
        convert_char(s_tdata, s_tlast);
        if (pin.pinned) begin
          prefix_bytes_q.push_back(pin.want);
        end else begin
          foreach (step_bytes[k]) prefix_bytes_q.push_back(step_bytes[k]);
        end
      end
      if (m_tvalid && m_tready) begin
        got = '{m_tdata, m_tuser[0], m_tlast, m_tuser[1], m_tuser[2]};
        if (prefix_bytes_q.size() == 0) begin
          $error("unexpected output transaction: out_char %h", m_tdata);
          errors++;
        end else begin
          want = prefix_bytes_q.pop_front();
          bytes_checked++;
          if (got.out_char !== want.out_char) begin
            $error("out_char: expected %h, actual %h", want.out_char, got.out_char);
            errors++;
          end
          if (got.char_valid !== want.char_valid) begin
            $error("char_valid: expected %b, actual %b", want.char_valid, got.char_valid);
            errors++;
          end
          if (got.run_last !== want.run_last) begin
            $error("run_last: expected %b, actual %b", want.run_last, got.run_last);
            errors++;
          end
          if (got.expr_end !== want.expr_end) begin
            $error("expression_end: expected %b, actual %b", want.expr_end, got.expr_end);
            errors++;
          end
          if (got.ovf !== want.ovf) begin
            $error("overflow_seen: expected %b, actual %b", want.ovf, got.ovf);
            errors++;
          end
          if (want.expr_end) exprs_closed++;
          if (want.ovf) ovf_results++;
        end
      end
    end
  end

  // Hard limit on run time.
  initial begin
    #25_000_000;
    $display("tb: failure");
    $finish;
  end

  // Main stimulus.
  initial begin
    int         kind;
    int         n;
    int         start_items;
    int         spot;
    logic [7:0] fill;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = 8'h00;
    s_tlast = 1'b0;
    m_tready = 1'b0;
    errors = 0;
    items_sent = 0;
    bytes_checked = 0;
    exprs_closed = 0;
    ovf_results = 0;
    stall_left = 0;
    steady = 1'b0;
    op_cnt = 0;
    ovf_flag = 1'b0;

    // Single-character expressions, byte extremes and the bare end marker are typed in.
    directed_rows[0]  = '{CH_LOW_A,  1'b1, 1'b1, '{CH_LOW_A, 1'b1, 1'b1, 1'b1, 1'b0}};
    directed_rows[1]  = '{CH_LPAREN, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0}};
    directed_rows[2]  = '{8'h00,     1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b1, 1'b0}};
    directed_rows[3]  = '{8'hFF,     1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b1, 1'b0}};
    directed_rows[4]  = '{CH_UP_Z,   1'b0, 1'b1, '{CH_UP_Z, 1'b1, 1'b1, 1'b0, 1'b0}};
    directed_rows[5]  = '{CH_LOW_Z,  1'b0, 1'b1, '{CH_LOW_Z, 1'b1, 1'b1, 1'b0, 1'b0}};
    directed_rows[6]  = '{CH_UP_A,   1'b1, 1'b1, '{CH_UP_A, 1'b1, 1'b1, 1'b1, 1'b0}};
    // (a+b)*c^d, fed last character first.
    directed_rows[7]  = '{"d",       1'b0, 1'b0, '0};
    directed_rows[8]  = '{CH_CARET,  1'b0, 1'b0, '0};
    directed_rows[9]  = '{"c",       1'b0, 1'b0, '0};
    directed_rows[10] = '{CH_STAR,   1'b0, 1'b0, '0};
    directed_rows[11] = '{CH_RPAREN, 1'b0, 1'b0, '0};
    directed_rows[12] = '{"b",       1'b0, 1'b0, '0};
    directed_rows[13] = '{CH_PLUS,   1'b0, 1'b0, '0};
    directed_rows[14] = '{CH_LOW_A,  1'b0, 1'b0, '0};
    directed_rows[15] = '{CH_LPAREN, 1'b1, 1'b0, '0};
    // x-y/w.
    directed_rows[16] = '{"w",       1'b0, 1'b0, '0};
    directed_rows[17] = '{CH_SLASH,  1'b0, 1'b0, '0};
    directed_rows[18] = '{"y",       1'b0, 1'b0, '0};
    directed_rows[19] = '{CH_MINUS,  1'b0, 1'b0, '0};
    directed_rows[20] = '{"x",       1'b1, 1'b0, '0};
    // Unmatched open paren, a digit and a blank treated as lowest-rank operators.
    directed_rows[21] = '{CH_PLUS,   1'b0, 1'b0, '0};
    directed_rows[22] = '{CH_LPAREN, 1'b0, 1'b0, '0};
    directed_rows[23] = '{"7",       1'b0, 1'b0, '0};
    directed_rows[24] = '{" ",       1'b0, 1'b0, '0};
    directed_rows[25] = '{"q",       1'b1, 1'b0, '0};

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table.
    foreach (directed_rows[i])
      feed_char(directed_rows[i].ch, directed_rows[i].is_first, directed_rows[i].pinned,
                directed_rows[i].want);

    // Random part: mostly well-formed expressions, some noise and stack overflow runs.
    start_items = items_sent;
    while (items_sent - start_items < 300) begin
      steady = ($urandom_range(0, 4) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        infix_q.delete();
        build_expr($urandom_range(0, 4));
        // Now and then one character of the expression is corrupted.
        if ($urandom_range(0, 9) == 0) begin
          spot = $urandom_range(0, infix_q.size() - 1);
          infix_q[spot] = 8'($urandom_range(0, 255));
        end
        for (int i = infix_q.size() - 1; i >= 0; i--)
          feed_char(infix_q[i], i == 0, 1'b0, '0);
      end else if (kind < 85) begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
          feed_char(8'($urandom_range(0, 255)), (i == n - 1) && $urandom_range(0, 1),
                    1'b0, '0);
      end else begin
        // Fill the stack from two below its depth to past it, then close with a letter.
        case ($urandom_range(0, 2))
          0: fill = CH_RPAREN;
          1: fill = CH_CARET;
          default: fill = 8'($urandom_range(CH_PLUS + 1, CH_MINUS - 1));
        endcase
        n = $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 8);
        for (int i = 0; i < n; i++)
          feed_char(fill, 1'b0, 1'b0, '0);
        feed_char(8'($urandom_range(CH_LOW_A, CH_LOW_Z)), 1'b1, 1'b0, '0);
      end
    end
    s_tvalid <= 1'b0;
    steady = 1'b0;

    // Let the last transaction be predicted, drain the prefix bytes, then watch for strays.
    @(posedge clk);
    while (prefix_bytes_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("Fed %0d infix characters, checked %0d prefix bytes.", items_sent, bytes_checked);
    $display("Closed %0d expressions, %0d output bytes carried the overflow flag.",
             exprs_closed, ovf_results);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
